/* design/tye_pkg.sv */
// ----------------------------------------------------------------------------
// tye_pkg: shared constants and tables for the tilt and yaw estimator
// Word and digit widths of the digit-serial CORDIC, the arctangent table and
// the fixed limits of the angle and yaw outputs.
// ----------------------------------------------------------------------------
package tye_pkg;

	localparam int IN_W        = 16;
	localparam int EXT_W       = IN_W + 1;
	localparam int ANG_W       = 16;
	localparam int YAW_W       = 32;
	localparam int DB_W        = 15;

	localparam int WORD_W      = 32;
	localparam int DIGIT_W     = 8;
	localparam int NUM_DIGITS  = WORD_W / DIGIT_W;
	localparam int DIG_IDX_W   = $clog2(NUM_DIGITS);
	localparam int CORDIC_STEPS = 20;
	localparam int STEP_IDX_W  = $clog2(CORDIC_STEPS);
	localparam int FRAC_SHIFT  = 12;
	localparam int ROUND_SHIFT = 9;

	localparam logic signed [WORD_W-1:0] HALF_TURN   = WORD_W'(11796480);
	localparam logic signed [WORD_W-1:0] ROUND_BIAS  = WORD_W'(256);
	localparam logic signed [WORD_W-1:0] ANGLE_LIMIT = WORD_W'(23040);
	localparam logic [DB_W-1:0]          DEADBAND_RESET = DB_W'(17);

	// atan(2^-i) in 1/65536 degree, rounded
	function automatic logic [WORD_W-1:0] atan_fine(input logic [STEP_IDX_W-1:0] idx);
		logic [WORD_W-1:0] t;
		unique case (idx)
			5'd0:    t = WORD_W'(2949120);
			5'd1:    t = WORD_W'(1740967);
			5'd2:    t = WORD_W'(919879);
			5'd3:    t = WORD_W'(466945);
			5'd4:    t = WORD_W'(234379);
			5'd5:    t = WORD_W'(117304);
			5'd6:    t = WORD_W'(58666);
			5'd7:    t = WORD_W'(29335);
			5'd8:    t = WORD_W'(14668);
			5'd9:    t = WORD_W'(7334);
			5'd10:   t = WORD_W'(3667);
			5'd11:   t = WORD_W'(1833);
			5'd12:   t = WORD_W'(917);
			5'd13:   t = WORD_W'(458);
			5'd14:   t = WORD_W'(229);
			5'd15:   t = WORD_W'(115);
			5'd16:   t = WORD_W'(57);
			5'd17:   t = WORD_W'(29);
			5'd18:   t = WORD_W'(14);
			5'd19:   t = WORD_W'(7);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

/* design/tilt_and_yaw_estimator.sv */
// ----------------------------------------------------------------------------
// tilt_and_yaw_estimator: pitch and roll from the accelerometer, yaw from gyro
// Two digit-serial CORDIC units give atan2 angles in 1/128 degree; a
// saturating accumulator integrates gyro Z, negated, past a programmable deadband.
// ----------------------------------------------------------------------------
// The input takes one word at a time: ready stays low from an accepted word
// until its result is written to the output register. The CORDIC runs 20 steps
//   of 4 digits each, then rounds the angle and hands the word over.
// The output register frees the input side while a result waits downstream.
// Reset clears yaw to 0, the deadband to 17 and the output valid flag.
module tilt_and_yaw_estimator (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [63:0]                s_axis_tdata,  // accel_x, accel_y, accel_z, gyro_z
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [63:0]                m_axis_tdata,  // pitch_angle, roll_angle, yaw_total
	input  logic                       cfg_we,
	input  logic [tye_pkg::DB_W-1:0]   cfg_wdata
);
	import tye_pkg::*;

	typedef enum logic [1:0] {T_IDLE, T_RUN, T_HOLD} tstate_t;

	tstate_t                  state_q;
	logic                     m_valid_q;
	logic [63:0]              m_data_q;

	logic                     in_word;
	logic                     out_free;
	logic signed [IN_W-1:0]   accel_x, accel_y, accel_z, gyro_z;
	logic                     pitch_done, roll_done;
	logic signed [ANG_W-1:0]  pitch_angle, roll_angle;
	logic signed [YAW_W-1:0]  yaw_total;

	assign accel_x = s_axis_tdata[15:0];
	assign accel_y = s_axis_tdata[31:16];
	assign accel_z = s_axis_tdata[47:32];
	assign gyro_z  = s_axis_tdata[63:48];

	assign s_axis_tready = (state_q == T_IDLE);
	assign in_word       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !m_valid_q || m_axis_tready;

	tye_cordic u_pitch (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_word),
		.num    (accel_x),
		.den    (accel_z),
		.done   (pitch_done),
		.angle  (pitch_angle)
	);

	tye_cordic u_roll (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_word),
		.num    (accel_y),
		.den    (accel_z),
		.done   (roll_done),
		.angle  (roll_angle)
	);

	tye_yaw u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.update    (in_word),
		.gyro_z    (gyro_z),
		.yaw_total (yaw_total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= T_IDLE;
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else begin
			if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				T_IDLE: begin
					if (in_word) begin
						state_q <= T_RUN;
					end
				end
				T_RUN: begin
					// both units run in lockstep and finish together
					if (pitch_done && roll_done) begin
						if (out_free) begin
							m_data_q  <= {yaw_total, roll_angle, pitch_angle};
							m_valid_q <= 1'b1;
							state_q   <= T_IDLE;
						end else begin
							state_q <= T_HOLD;
						end
					end
				end
				T_HOLD: begin
					// hold the finished word until the output register frees
					if (out_free) begin
						m_data_q  <= {yaw_total, roll_angle, pitch_angle};
						m_valid_q <= 1'b1;
						state_q   <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

/* design/tye_cordic.sv */
// ----------------------------------------------------------------------------
// tye_cordic: digit-serial vectoring CORDIC for atan2
// Each rotation step updates x, y and z one 8-bit digit per cycle, LSB first,
// with a carry flop per word; the old words stay put until the last digit.
// ----------------------------------------------------------------------------
module tye_cordic (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [tye_pkg::IN_W-1:0]  num,
	input  logic signed [tye_pkg::IN_W-1:0]  den,
	output logic                          done,
	output logic signed [tye_pkg::ANG_W-1:0] angle
);
	import tye_pkg::*;

	typedef enum logic [1:0] {C_IDLE, C_RUN, C_FIN} cstate_t;

	cstate_t                  state_q;
	logic [STEP_IDX_W-1:0]    i_q;
	logic [DIG_IDX_W-1:0]     k_q;
	logic                     done_q;
	logic signed [ANG_W-1:0]  angle_q;

	logic signed [WORD_W-1:0] x_q, y_q, z_q;
	logic [WORD_W-1:0]        xn_q, yn_q, zn_q;
	logic                     cx_q, cy_q, cz_q;
	logic                     zero_q;

	logic                     neg;
	logic signed [EXT_W-1:0]  num_e, den_e, xl, yl;
	logic signed [WORD_W-1:0] dx, dy, zr, r, r_cl;
	logic [WORD_W-1:0]        tw;
	logic [DIGIT_W-1:0]       xd, yd, zd, dxd, dyd, td;
	logic                     dir, first, cin_x, cin_y, cin_z;
	logic [DIGIT_W:0]         sx, sy, sz;
	logic                     last_dig, last_step;

	// operand set-up: fold the left half plane onto the right
	assign neg   = den[IN_W-1];
	assign num_e = {num[IN_W-1], num};
	assign den_e = {den[IN_W-1], den};
	assign xl    = neg ? -den_e : den_e;
	assign yl    = neg ? -num_e : num_e;

	// one digit of each update
	assign dx    = y_q >>> i_q;
	assign dy    = x_q >>> i_q;
	assign tw    = atan_fine(i_q);
	assign xd    = x_q[k_q*DIGIT_W +: DIGIT_W];
	assign yd    = y_q[k_q*DIGIT_W +: DIGIT_W];
	assign zd    = z_q[k_q*DIGIT_W +: DIGIT_W];
	assign dxd   = dx[k_q*DIGIT_W +: DIGIT_W];
	assign dyd   = dy[k_q*DIGIT_W +: DIGIT_W];
	assign td    = tw[k_q*DIGIT_W +: DIGIT_W];
	assign dir   = !y_q[WORD_W-1] && (|y_q);
	assign first = (k_q == '0);
	assign cin_x = first ? !dir : cx_q;
	assign cin_y = first ? dir  : cy_q;
	assign cin_z = first ? !dir : cz_q;
	assign sx    = {1'b0, xd} + {1'b0, (dir ? dxd : ~dxd)} + {{DIGIT_W{1'b0}}, cin_x};
	assign sy    = {1'b0, yd} + {1'b0, (dir ? ~dyd : dyd)} + {{DIGIT_W{1'b0}}, cin_y};
	assign sz    = {1'b0, zd} + {1'b0, (dir ? td : ~td)} + {{DIGIT_W{1'b0}}, cin_z};

	assign last_dig  = (k_q == DIG_IDX_W'(NUM_DIGITS-1));
	assign last_step = (i_q == STEP_IDX_W'(CORDIC_STEPS-1));

	// round to 1/128 degree and clamp
	assign zr   = z_q + ROUND_BIAS;
	assign r    = zr >>> ROUND_SHIFT;
	always_comb begin
		if (r > ANGLE_LIMIT) begin
			r_cl = ANGLE_LIMIT;
		end else if (r < -ANGLE_LIMIT) begin
			r_cl = -ANGLE_LIMIT;
		end else begin
			r_cl = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			done_q  <= 1'b0;
			angle_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						i_q     <= '0;
						k_q     <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					k_q <= k_q + 1'b1;
					if (last_dig) begin
						k_q <= '0;
						i_q <= i_q + 1'b1;
						if (last_step) begin
							state_q <= C_FIN;
						end
					end
				end
				C_FIN: begin
					angle_q <= zero_q ? '0 : r_cl[ANG_W-1:0];
					done_q  <= 1'b1;
					state_q <= C_IDLE;
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == C_IDLE && start) begin
			x_q    <= {{(WORD_W-EXT_W-FRAC_SHIFT){xl[EXT_W-1]}}, xl, {FRAC_SHIFT{1'b0}}};
			y_q    <= {{(WORD_W-EXT_W-FRAC_SHIFT){yl[EXT_W-1]}}, yl, {FRAC_SHIFT{1'b0}}};
			z_q    <= neg ? (num[IN_W-1] ? -HALF_TURN : HALF_TURN) : '0;
			zero_q <= (den == '0) && (num == '0);
		end else if (state_q == C_RUN) begin
			cx_q <= sx[DIGIT_W];
			cy_q <= sy[DIGIT_W];
			cz_q <= sz[DIGIT_W];
			// shift the new digit in from the top
			xn_q <= {sx[DIGIT_W-1:0], xn_q[WORD_W-1:DIGIT_W]};
			yn_q <= {sy[DIGIT_W-1:0], yn_q[WORD_W-1:DIGIT_W]};
			zn_q <= {sz[DIGIT_W-1:0], zn_q[WORD_W-1:DIGIT_W]};
			if (last_dig) begin
				x_q <= {sx[DIGIT_W-1:0], xn_q[WORD_W-1:DIGIT_W]};
				y_q <= {sy[DIGIT_W-1:0], yn_q[WORD_W-1:DIGIT_W]};
				z_q <= {sz[DIGIT_W-1:0], zn_q[WORD_W-1:DIGIT_W]};
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

/* design/tye_yaw.sv */
// ----------------------------------------------------------------------------
// tye_yaw: deadband register and saturating yaw accumulator
// Subtracts gyro Z from the running sum when its magnitude reaches the
// deadband; the sum clips at the signed 32-bit limits.
// ----------------------------------------------------------------------------
module tye_yaw (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tye_pkg::DB_W-1:0]        cfg_wdata,
	input  logic                            update,
	input  logic signed [tye_pkg::IN_W-1:0] gyro_z,
	output logic signed [tye_pkg::YAW_W-1:0] yaw_total
);
	import tye_pkg::*;

	logic [DB_W-1:0]          deadband_q;
	logic signed [YAW_W-1:0]  yaw_q;
	logic [EXT_W-1:0]         gz_e, mag;
	logic [YAW_W:0]           diff;
	logic signed [YAW_W-1:0]  yaw_next;

	assign gz_e = {gyro_z[IN_W-1], gyro_z};
	assign mag  = gyro_z[IN_W-1] ? (~gz_e + 1'b1) : gz_e;
	assign diff = {yaw_q[YAW_W-1], yaw_q} - {{(YAW_W+1-IN_W){gyro_z[IN_W-1]}}, gyro_z};

	// clip when the two top bits disagree
	always_comb begin
		if (diff[YAW_W] != diff[YAW_W-1]) begin
			yaw_next = diff[YAW_W] ? {1'b1, {(YAW_W-1){1'b0}}} : {1'b0, {(YAW_W-1){1'b1}}};
		end else begin
			yaw_next = diff[YAW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q <= DEADBAND_RESET;
			yaw_q      <= '0;
		end else begin
			if (cfg_we) begin
				deadband_q <= cfg_wdata;
			end
			if (update && (mag >= {{(EXT_W-DB_W){1'b0}}, deadband_q})) begin
				yaw_q <= yaw_next;
			end
		end
	end

	assign yaw_total = yaw_q;

endmodule

/* design/tye_checker.sv */
// ----------------------------------------------------------------------------
// tye_assert: port-level checks for the tilt and yaw estimator
// Watches the stream handshakes and the output angle range.
// ----------------------------------------------------------------------------
module tye_assert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata
);

	// one word in flight: input closes right after a word is taken
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input ready stayed high after an accepted word");

	// a result never shows up the cycle after its word was taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !$rose(m_axis_tvalid))
		else $error("result appeared too early");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("output word dropped or changed while stalled");

	// both angles stay within a half turn
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (($signed(m_axis_tdata[15:0]) <= 16'sd23040)
			&& ($signed(m_axis_tdata[15:0]) >= -16'sd23040)
			&& ($signed(m_axis_tdata[31:16]) <= 16'sd23040)
			&& ($signed(m_axis_tdata[31:16]) >= -16'sd23040)))
		else $error("angle out of range");

	// reset clears the output valid flag by the next edge
	a_reset_idle: assert property (@(posedge clk) !arst_n |=> !m_axis_tvalid)
		else $error("output valid during reset");

endmodule

bind tilt_and_yaw_estimator tye_assert u_tye_checker (.*);
